>>> rtl/ffha_pkg.sv
// Package: constants and FSM state type for the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_UNITS   = 4096;
  localparam int PAGE_UNITS   = 256;
  localparam int HEADER_UNITS = 1;

  localparam int ADDR_W = 12;   // index into the chunk stores
  localparam int SIZE_W = 13;   // chunk sizes, heap top, in-use total
  localparam int PAGE_SHIFT = 8;
  localparam int MAX_PAGES = HEAP_UNITS / PAGE_UNITS;
  localparam int ENTRY_W = SIZE_W + 1;  // {used, size}

  localparam logic [SIZE_W-1:0] USED_MAX = 13'h1FFF;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOM = 1'b1;

  localparam logic [0:0] REG_LIMIT_PAGES = 1'b0;
  localparam logic [0:0] REG_MIN_CHUNK   = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,      // write entry 0 after reset
    ST_IDLE,
    ST_A_READ,    // allocate: issue header read at pos
    ST_A_EVAL,    // allocate: header data back
    ST_A_SPLIT,   // allocate: write split remainder
    ST_A_MARK,    // allocate: write used header
    ST_R_READ,
    ST_R_EVAL,
    ST_R_NREAD,   // release: read following chunk
    ST_R_NEVAL,
    ST_R_WRITE,
    ST_DONE
  } state_t;

endpackage

>>> rtl/first_fit_heap_allocator.sv
// Top level: first-fit heap allocator with split and coalesce.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in_     | input     | in_valid / in_ready    | kind, request_size, release_address
//  out_    | output    | out_valid / out_ready  | data_address, status, units_used
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One transaction at a time. Allocate visits each chunk header in a read state
// and an evaluate state, then does the split and mark writes; growth rides in
// the read state of the header at heap top.
// Release reads and evaluates its own header, then reads and evaluates each
// following chunk examined (the one that stops the merge included), then writes back.
// The single RAM port allows one header access per cycle.
// After reset the INIT state initializes chunk 0; in_ready stays low until then.
// The result register holds until out_ready; a new transaction starts only then.
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [11:0] in_request_size,
  input  logic [11:0] in_release_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_data_address,
  output logic        out_status,
  output logic [12:0] out_units_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int AW = ffha_pkg::ADDR_W;
  localparam int SW = ffha_pkg::SIZE_W;

  ffha_pkg::state_t state_r, state_nxt;

  // config
  logic [4:0] limit_pages_r;
  logic [8:0] min_chunk_r;

  // architectural state
  logic [SW-1:0] heap_top_r, heap_top_nxt;
  logic [SW-1:0] in_use_r, in_use_nxt;

  // working registers
  logic          kind_r;
  logic [SW-1:0] need_r, need_nxt;
  logic [SW-1:0] pos_r, pos_nxt;     // current chunk offset (13b to see HEAP_UNITS)
  logic [SW-1:0] sz_r, sz_nxt;       // size of chunk at pos
  logic [SW-1:0] nxt_r, nxt_nxt;     // following chunk offset during merge
  logic          rel_hit_r, rel_hit_nxt;
  logic [AW-1:0] out_addr_r, out_addr_nxt;
  logic          out_status_r, out_status_nxt;

  // RAM port
  logic                      ram_we;
  logic [AW-1:0]             ram_addr;
  logic [ffha_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic                      rd_used;
  logic [SW-1:0]             rd_size;

  ffha_ram #(
    .WIDTH(ffha_pkg::ENTRY_W),
    .DEPTH(ffha_pkg::HEAP_UNITS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign rd_used = ram_rdata[SW];
  assign rd_size = ram_rdata[SW-1:0];

  // effective config values
  logic [SW-1:0] min_eff, limit_units;
  logic [4:0]    pages_eff;
  always_comb begin
    min_eff = (min_chunk_r < 9'd2) ? SW'(2) : SW'(min_chunk_r);
    pages_eff = (limit_pages_r > 5'(ffha_pkg::MAX_PAGES)) ?
                5'(ffha_pkg::MAX_PAGES) : limit_pages_r;
    limit_units = SW'({pages_eff, {ffha_pkg::PAGE_SHIFT{1'b0}}});
  end

  // request decode
  logic [SW-1:0] req_need;
  always_comb begin
    req_need = SW'(in_request_size) + SW'(ffha_pkg::HEADER_UNITS);
    if (req_need < min_eff) req_need = min_eff;
  end

  // growth amount (need / page + 1) pages; 14 bits so the sum cannot wrap
  logic [SW:0] grow, grown_top;
  always_comb begin
    grow = ({1'b0, need_r} >> ffha_pkg::PAGE_SHIFT) + (SW+1)'(1);
    grow = grow << ffha_pkg::PAGE_SHIFT;
    grown_top = {1'b0, heap_top_r} + grow;
  end

  // growth write lands at pos while RAM reads old data: patch the read path
  logic          grew_r;
  logic [SW-1:0] grow_sz_r;

  // evaluation view of a freshly grown chunk: free, size = grow
  logic          ev_used;
  logic [SW-1:0] ev_size;
  assign ev_used = grew_r ? 1'b0 : rd_used;
  assign ev_size = grew_r ? grow_sz_r : rd_size;

  logic [SW:0] pos_end, nxt_end, split_pos;
  logic [SW-1:0] rem;
  logic [SW:0] use_sum;
  always_comb begin
    pos_end   = {1'b0, pos_r} + {1'b0, ev_size};
    nxt_end   = {1'b0, nxt_r} + {1'b0, rd_size};
    split_pos = {1'b0, pos_r} + {1'b0, need_r};
    rem       = sz_r - need_r;
    use_sum   = {1'b0, in_use_r} + {1'b0, sz_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffha_pkg::ST_INIT:  state_nxt = ffha_pkg::ST_IDLE;
      ffha_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = (in_kind == ffha_pkg::KIND_ALLOC) ?
                                  ffha_pkg::ST_A_READ : ffha_pkg::ST_R_READ;
      end
      ffha_pkg::ST_A_READ: begin
        priority if (pos_r > heap_top_r)             state_nxt = ffha_pkg::ST_DONE;
        else if (pos_r == heap_top_r) begin
          if (grown_top > {1'b0, limit_units})       state_nxt = ffha_pkg::ST_DONE;
          else                                       state_nxt = ffha_pkg::ST_A_EVAL;
        end
        else if (pos_r >= SW'(ffha_pkg::HEAP_UNITS)) state_nxt = ffha_pkg::ST_DONE;
        else                                         state_nxt = ffha_pkg::ST_A_EVAL;
      end
      ffha_pkg::ST_A_EVAL: begin
        priority if (!ev_used && ev_size >= need_r)  state_nxt = ffha_pkg::ST_A_SPLIT;
        else if (ev_size == '0 || pos_end > {1'b0, heap_top_r})
                                                     state_nxt = ffha_pkg::ST_DONE;
        else                                         state_nxt = ffha_pkg::ST_A_READ;
      end
      ffha_pkg::ST_A_SPLIT: state_nxt = ffha_pkg::ST_A_MARK;
      ffha_pkg::ST_A_MARK:  state_nxt = ffha_pkg::ST_DONE;
      ffha_pkg::ST_R_READ: begin
        if (pos_r >= heap_top_r || pos_r >= SW'(ffha_pkg::HEAP_UNITS) || !rel_hit_r)
          state_nxt = ffha_pkg::ST_DONE;
        else
          state_nxt = ffha_pkg::ST_R_EVAL;
      end
      ffha_pkg::ST_R_EVAL: begin
        if (!rd_used) state_nxt = ffha_pkg::ST_DONE;
        else          state_nxt = ffha_pkg::ST_R_NREAD;
      end
      ffha_pkg::ST_R_NREAD: begin
        if (nxt_r >= heap_top_r || nxt_r >= SW'(ffha_pkg::HEAP_UNITS))
          state_nxt = ffha_pkg::ST_R_WRITE;
        else
          state_nxt = ffha_pkg::ST_R_NEVAL;
      end
      ffha_pkg::ST_R_NEVAL: begin
        if (rd_used || rd_size == '0 || nxt_end > {1'b0, heap_top_r})
          state_nxt = ffha_pkg::ST_R_WRITE;
        else
          state_nxt = ffha_pkg::ST_R_NREAD;
      end
      ffha_pkg::ST_R_WRITE: state_nxt = ffha_pkg::ST_DONE;
      ffha_pkg::ST_DONE:    if (out_ready) state_nxt = ffha_pkg::ST_IDLE;
      default:              state_nxt = ffha_pkg::ST_INIT;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    heap_top_nxt   = heap_top_r;
    in_use_nxt     = in_use_r;
    need_nxt       = need_r;
    pos_nxt        = pos_r;
    sz_nxt         = sz_r;
    nxt_nxt        = nxt_r;
    rel_hit_nxt    = rel_hit_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_addr       = pos_r[AW-1:0];
    ram_wdata      = {1'b0, sz_r};
    unique case (state_r)
      ffha_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_addr  = '0;
        ram_wdata = {1'b0, SW'(ffha_pkg::PAGE_UNITS)};
      end
      ffha_pkg::ST_IDLE: begin
        need_nxt       = req_need;
        pos_nxt        = '0;
        out_addr_nxt   = '0;
        out_status_nxt = ffha_pkg::STATUS_OK;
        rel_hit_nxt    = in_release_address >= AW'(ffha_pkg::HEADER_UNITS);
        if (in_kind == ffha_pkg::KIND_RELEASE)
          pos_nxt = SW'(in_release_address - AW'(ffha_pkg::HEADER_UNITS));
      end
      ffha_pkg::ST_A_READ: begin
        priority if (pos_r > heap_top_r) out_status_nxt = ffha_pkg::STATUS_OOM;
        else if (pos_r == heap_top_r) begin
          if (grown_top > {1'b0, limit_units}) out_status_nxt = ffha_pkg::STATUS_OOM;
          else begin
            // new free chunk; the read returns old data, grew_r forwards the new one
            ram_we       = 1'b1;
            ram_wdata    = {1'b0, grow[SW-1:0]};
            heap_top_nxt = grown_top[SW-1:0];
          end
        end
        else if (pos_r >= SW'(ffha_pkg::HEAP_UNITS)) out_status_nxt = ffha_pkg::STATUS_OOM;
        else ;
      end
      ffha_pkg::ST_A_EVAL: begin
        sz_nxt = ev_size;
        priority if (!ev_used && ev_size >= need_r) ;
        else if (ev_size == '0 || pos_end > {1'b0, heap_top_r})
          out_status_nxt = ffha_pkg::STATUS_OOM;
        else
          pos_nxt = pos_end[SW-1:0];
      end
      ffha_pkg::ST_A_SPLIT: begin
        if (rem >= min_eff && split_pos < (SW+1)'(ffha_pkg::HEAP_UNITS)) begin
          ram_we    = 1'b1;
          ram_addr  = split_pos[AW-1:0];
          ram_wdata = {1'b0, rem};
          sz_nxt    = need_r;
        end
      end
      ffha_pkg::ST_A_MARK: begin
        ram_we       = 1'b1;
        ram_wdata    = {1'b1, sz_r};
        in_use_nxt   = (use_sum > {1'b0, ffha_pkg::USED_MAX}) ?
                       ffha_pkg::USED_MAX : use_sum[SW-1:0];
        out_addr_nxt = AW'(pos_r[AW-1:0] + AW'(ffha_pkg::HEADER_UNITS));
      end
      ffha_pkg::ST_R_READ: ;
      ffha_pkg::ST_R_EVAL: begin
        sz_nxt  = rd_size;
        nxt_nxt = pos_end[SW-1:0];
        if (rd_used)
          in_use_nxt = (in_use_r > rd_size) ? in_use_r - rd_size : '0;
      end
      ffha_pkg::ST_R_NREAD: ram_addr = nxt_r[AW-1:0];
      ffha_pkg::ST_R_NEVAL: begin
        if (!(rd_used || rd_size == '0 || nxt_end > {1'b0, heap_top_r})) begin
          sz_nxt  = sz_r + rd_size;
          nxt_nxt = nxt_end[SW-1:0];
        end
      end
      ffha_pkg::ST_R_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b0, sz_r};
      end
      ffha_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ffha_pkg::ST_INIT;
      limit_pages_r <= 5'd16;
      min_chunk_r   <= 9'd4;
      heap_top_r    <= SW'(ffha_pkg::PAGE_UNITS);
      in_use_r      <= '0;
      grew_r        <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      heap_top_r <= heap_top_nxt;
      in_use_r   <= in_use_nxt;
      grew_r     <= (state_r == ffha_pkg::ST_A_READ) && ram_we;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ffha_pkg::REG_LIMIT_PAGES) limit_pages_r <= cfg_data[4:0];
        else                                        min_chunk_r   <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    need_r       <= need_nxt;
    pos_r        <= pos_nxt;
    sz_r         <= sz_nxt;
    nxt_r        <= nxt_nxt;
    rel_hit_r    <= rel_hit_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    kind_r       <= (state_r == ffha_pkg::ST_IDLE) ? in_kind : kind_r;
    grow_sz_r    <= grow[SW-1:0];
  end

  assign in_ready         = (state_r == ffha_pkg::ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = (state_r == ffha_pkg::ST_DONE);
  assign out_data_address = out_addr_r;
  assign out_status       = out_status_r;
  assign out_units_used   = in_use_r;

  // a grown chunk must already satisfy the request, so its eval sees it free
  assert property (@(posedge clk) disable iff (!rst_n)
    grew_r |-> (ev_size >= need_r && !ev_used && kind_r == ffha_pkg::KIND_ALLOC))
    else $error("grown chunk too small");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ffha_pkg::STATUS_OK || out_data_address == '0))
    else $error("failed request carries an address");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ffha_pkg::ST_INIT) |-> heap_top_r <= limit_units ||
      $stable(heap_top_r))
    else $error("heap top changed beyond limit");

endmodule

>>> rtl/ffha_ram.sv
// Generic single-port synchronous RAM with registered read.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> dv/first_fit_heap_allocator_tb.sv
// Testbench for the first-fit heap allocator: random stimulus, scoreboard with heap predictor.
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;

  // Expected result of one request transaction
  typedef struct {
    logic [11:0] data_address;
    logic        status;
    logic [12:0] units_used;
  } heap_result_t;

  // Scoreboard: keeps its own copy of the chunk chain and predicts each result.
  class heap_scoreboard;
    logic [12:0]  chunk_size [ffha_pkg::HEAP_UNITS];
    bit           chunk_used [ffha_pkg::HEAP_UNITS];
    int unsigned  heap_top;
    int unsigned  in_use;
    int unsigned  limit_pages;
    int unsigned  min_chunk;
    heap_result_t pending_results[$];
    logic [11:0]  live_addrs[$];      // data offsets currently handed out
    logic [11:0]  freed_addrs[$];     // offsets released at least once
    int           errors;

    function new();
      for (int i = 0; i < ffha_pkg::HEAP_UNITS; i++) begin
        chunk_size[i] = '0;
        chunk_used[i] = 1'b0;
      end
      chunk_size[0] = 13'(ffha_pkg::PAGE_UNITS);
      heap_top      = ffha_pkg::PAGE_UNITS;
      in_use        = 0;
      limit_pages   = 16;
      min_chunk     = 4;
      errors        = 0;
    endfunction

    function void write_reg(logic idx, logic [8:0] data);
      if (idx == ffha_pkg::REG_LIMIT_PAGES[0]) limit_pages = data[4:0];
      else min_chunk = data;
    endfunction

    function bit try_alloc(int unsigned req, output int unsigned addr);
      int unsigned minc, need, pos, sz, rem, grow, lim;
      minc = (min_chunk < 2) ? 2 : min_chunk;
      lim  = ((limit_pages > ffha_pkg::MAX_PAGES) ? ffha_pkg::MAX_PAGES : limit_pages) *
             ffha_pkg::PAGE_UNITS;
      need = ffha_pkg::HEADER_UNITS + req;
      if (need < minc) need = minc;
      pos  = 0;
      addr = 0;
      forever begin
        if (pos >= heap_top) begin
          grow = (need / ffha_pkg::PAGE_UNITS + 1) * ffha_pkg::PAGE_UNITS;
          if (pos != heap_top || heap_top + grow > lim) return 1'b0;
          chunk_size[pos] = 13'(grow);
          chunk_used[pos] = 1'b0;
          heap_top += grow;
        end
        if (pos >= ffha_pkg::HEAP_UNITS) return 1'b0;
        sz = chunk_size[pos];
        if (!chunk_used[pos] && sz >= need) break;
        if (sz == 0 || pos + sz > heap_top) return 1'b0;
        pos += sz;
      end
      rem = sz - need;
      if (rem >= minc && pos + need < ffha_pkg::HEAP_UNITS) begin
        chunk_size[pos + need] = 13'(rem);
        chunk_used[pos + need] = 1'b0;
        chunk_size[pos]        = 13'(need);
      end
      chunk_used[pos] = 1'b1;
      in_use += chunk_size[pos];
      if (in_use > ffha_pkg::USED_MAX) in_use = ffha_pkg::USED_MAX;
      addr = pos + ffha_pkg::HEADER_UNITS;
      return 1'b1;
    endfunction

    function void do_release(int unsigned addr);
      int unsigned pos, sz, nxt, nsz;
      if (addr < ffha_pkg::HEADER_UNITS) return;
      pos = addr - ffha_pkg::HEADER_UNITS;
      if (pos >= heap_top || pos >= ffha_pkg::HEAP_UNITS) return;
      if (!chunk_used[pos]) return;
      chunk_used[pos] = 1'b0;
      sz = chunk_size[pos];
      in_use = (in_use > sz) ? in_use - sz : 0;
      forever begin
        nxt = pos + sz;
        if (nxt >= heap_top || nxt >= ffha_pkg::HEAP_UNITS) break;
        if (chunk_used[nxt]) break;
        nsz = chunk_size[nxt];
        if (nsz == 0 || nxt + nsz > heap_top) break;
        sz += nsz;
      end
      chunk_size[pos] = 13'(sz);
      foreach (live_addrs[i])
        if (live_addrs[i] == addr) begin
          live_addrs.delete(i);
          break;
        end
      freed_addrs.push_back(12'(addr));
    endfunction

    // Accepted request: update state, queue the expected result
    function void note_request(logic kind, logic [11:0] req, logic [11:0] rel);
      heap_result_t r;
      int unsigned a;
      r.data_address = '0;
      r.status       = ffha_pkg::STATUS_OK;
      if (kind == ffha_pkg::KIND_ALLOC) begin
        if (try_alloc(req, a)) begin
          r.data_address = 12'(a);
          live_addrs.push_back(12'(a));
        end else r.status = ffha_pkg::STATUS_OOM;
      end else do_release(rel);
      r.units_used = 13'(in_use);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [11:0] addr, logic status, logic [12:0] used);
      heap_result_t r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result addr=%0d status=%0d used=%0d",
                 $time, addr, status, used);
        errors++;
        return;
      end
      r = pending_results.pop_front();
      if (addr !== r.data_address) begin
        $display("%0t: data_address expected %0d actual %0d", $time, r.data_address, addr);
        errors++;
      end
      if (status !== r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, r.status, status);
        errors++;
      end
      if (used !== r.units_used) begin
        $display("%0t: units_used expected %0d actual %0d", $time, r.units_used, used);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 30000;   // idle cycles before giving up
  localparam int NUM_PHASES  = 6;
  localparam int RANDOM_PER_PHASE = 150;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [11:0] in_request_size;
  logic [11:0] in_release_address;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] out_data_address;
  logic        out_status;
  logic [12:0] out_units_used;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [8:0]  cfg_data;

  heap_scoreboard sb;
  int unsigned    idle_cycles;
  int unsigned    cyc;
  int unsigned    stall_mode;

  first_fit_heap_allocator dut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Receiver: check every accepted result; out_ready follows a mode that is
  // picked anew at random (always ready, sparse, random, periodic).
  // The watchdog lives here too.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_data_address, out_status, out_units_used);
    cyc <= cyc + 1;
    if (cyc % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) == 0);
      2: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (cyc % 8) < 5;
    endcase
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One request transaction; returns right after the accepting edge.
  // in_valid stays high so the caller may chain the next one.
  task automatic send_request(logic kind, logic [11:0] req, logic [11:0] rel);
    in_valid           <= 1'b1;
    in_kind            <= kind;
    in_request_size    <= req;
    in_release_address <= rel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(kind, req, rel);
  endtask

  task automatic write_reg(logic idx, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // Registers change only with nothing in flight
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Address past heap top, or offset zero when the heap is full
  function automatic logic [11:0] beyond_top_addr();
    if (sb.heap_top >= ffha_pkg::HEAP_UNITS - 1) return 12'd0;
    return 12'($urandom_range(sb.heap_top + ffha_pkg::HEADER_UNITS,
                              ffha_pkg::HEAP_UNITS - 1));
  endfunction

  function automatic logic [11:0] random_size();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 65) return 12'($urandom_range(0, 60));
    if (p < 88) return 12'($urandom_range(61, 600));
    if (p < 97) return 12'($urandom_range(601, 2000));
    return 12'($urandom_range(2001, 4095));
  endfunction

  // Random request: mostly allocate/release of live chunks, some noise
  task automatic send_random();
    int unsigned p;
    logic [11:0] a;
    p = $urandom_range(0, 99);
    if (p < 42 && sb.live_addrs.size() != 0) begin
      a = sb.live_addrs[$urandom_range(0, sb.live_addrs.size() - 1)];
      send_request(ffha_pkg::KIND_RELEASE, 12'($urandom), a);
    end else if (p < 47 && sb.freed_addrs.size() != 0) begin
      // stale or double release
      a = sb.freed_addrs[$urandom_range(0, sb.freed_addrs.size() - 1)];
      send_request(ffha_pkg::KIND_RELEASE, 12'($urandom), a);
    end else if (p < 50) begin
      send_request(ffha_pkg::KIND_RELEASE, 12'($urandom),
                   ($urandom_range(0, 1) != 0) ? 12'd0 : beyond_top_addr());
    end else
      send_request(ffha_pkg::KIND_ALLOC, random_size(), 12'($urandom));
  endtask

  initial begin
    logic [4:0]  limits[NUM_PHASES];
    logic [8:0]  mins[NUM_PHASES];
    int unsigned burst, gap;
    logic [11:0] a;

    limits = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd16};
    mins   = '{9'd2, 9'd256, 9'd0, 9'd4, 9'd511, 9'd3};
    sb                 = new();
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_kind            = ffha_pkg::KIND_ALLOC;
    in_request_size    = '0;
    in_release_address = '0;
    out_ready          = 1'b0;
    cfg_valid          = 1'b0;
    cfg_index          = ffha_pkg::REG_LIMIT_PAGES[0];
    cfg_data           = '0;
    idle_cycles        = 0;
    cyc                = 0;
    stall_mode         = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings first, back to back
    send_request(ffha_pkg::KIND_ALLOC, 12'd0, 12'hFFF);      // smallest, split off page
    send_request(ffha_pkg::KIND_ALLOC, 12'd254, 12'h000);    // walk past, grow
    send_request(ffha_pkg::KIND_ALLOC, 12'd4095, 12'hFFF);   // growth past limit
    send_request(ffha_pkg::KIND_RELEASE, 12'hFFF, 12'd0);    // below header
    send_request(ffha_pkg::KIND_RELEASE, 12'h000, 12'd4095); // past heap top
    a = sb.live_addrs[0];
    send_request(ffha_pkg::KIND_RELEASE, 12'h000, a);        // real release, merge
    send_request(ffha_pkg::KIND_RELEASE, 12'hFFF, a);        // release of free chunk
    send_request(ffha_pkg::KIND_ALLOC, 12'd1, 12'd0);        // reuse first chunk
    send_request(ffha_pkg::KIND_ALLOC, 12'd2, 12'd0);        // splits the remainder again
    send_request(ffha_pkg::KIND_ALLOC, 12'd1000, 12'd0);     // multi-page growth
    while (sb.live_addrs.size() != 0)
      send_request(ffha_pkg::KIND_RELEASE, 12'd0, sb.live_addrs[0]);
    send_request(ffha_pkg::KIND_ALLOC, 12'd255, 12'd0);      // header plus data fill exactly one page
    drain();

    // Phases: new settings, then bursts of random requests
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(ffha_pkg::REG_LIMIT_PAGES[0], {4'd0, limits[ph]});
      write_reg(ffha_pkg::REG_MIN_CHUNK[0], mins[ph]);
      for (int n = 0; n < RANDOM_PER_PHASE; ) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst && n < RANDOM_PER_PHASE; b++, n++) send_random();
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
